// ----- rtl/chg_pkg.sv -----
// Shared types, constants and a lookup function for the charge PWM limiter.
// No dependencies.
`default_nettype none
package chg_pkg;

    localparam int unsigned MV_W      = 13;
    localparam int unsigned TEMP_W    = 11;
    localparam int unsigned EXP_W     = 3;
    localparam int unsigned PACK_W    = 16;
    localparam int unsigned DUTY_W    = 7;
    localparam int unsigned LVL_W     = 10;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 13;

    localparam int unsigned DEF_CELLS = 72;

    localparam logic [LVL_W-1:0] LVL_MAX = 10'd915;
    localparam logic [LVL_W-1:0] LVL_RUN = 10'd130;

    // Q1.16 ratio and the pieces of the level datapath
    localparam int unsigned RATIO_W   = 17;
    localparam int unsigned LVLQ_W    = 26;   // level with 16 fraction bits
    localparam int unsigned PROD_W    = 34;   // level times derating factor
    localparam logic [7:0]  FACTOR_ONE = 8'd200;

    localparam int unsigned DIV_STEPS    = 17;
    localparam int unsigned DIV_PER_STG  = 2;
    localparam int unsigned DIV_STAGES   = (DIV_STEPS + DIV_PER_STG - 1) / DIV_PER_STG;
    localparam int unsigned POW_STAGES   = 7;

    // product/(200*2^16) = (product>>19)/25, the /25 by reciprocal multiply
    localparam int unsigned SCALE_SH  = 19;
    localparam int unsigned SC_N_W    = PROD_W - SCALE_SH;
    localparam int unsigned RECIP_W   = 16;
    localparam int unsigned SC_W      = SC_N_W + RECIP_W;
    localparam int unsigned RECIP_SH  = 20;
    localparam logic [RECIP_W-1:0] RECIP25 = 16'd41944;   // ceil(2^20/25)
    // derated level above 1.0: floor(product/200) > 65536
    localparam logic [PROD_W-1:0]  ABOVE_ONE = 34'd13107400;

    // reset values
    localparam logic [EXP_W-1:0]  RST_RAMP_UP   = 3'd5;
    localparam logic [EXP_W-1:0]  RST_RAMP_DOWN = 3'd3;
    localparam logic [MV_W-1:0]   RST_CELL_LOW  = 13'd3000;
    localparam logic [MV_W-1:0]   RST_TAPER     = 13'd4000;
    localparam logic [MV_W-1:0]   RST_LIMIT     = 13'd4160;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_MIN  = 11'sd0;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_PREF = 11'sd100;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_MAX  = 11'sd450;

    typedef enum logic [CFG_IDX_W-1:0] {
        IDX_RAMP_UP   = 3'd0,
        IDX_RAMP_DOWN = 3'd1,
        IDX_CELL_LOW  = 3'd2,
        IDX_TAPER     = 3'd3,
        IDX_LIMIT     = 3'd4,
        IDX_TEMP_MIN  = 3'd5,
        IDX_TEMP_PREF = 3'd6,
        IDX_TEMP_MAX  = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_ZERO = 2'd0,
        KIND_FULL = 2'd1,
        KIND_RAMP = 2'd2
    } kind_t;

    // per-item side info carried alongside the arithmetic
    typedef struct packed {
        kind_t             kind;
        logic [7:0]        factor;
        logic              trickle;
        logic              evse;
        logic [LVL_W-1:0]  evse_lvl;
    } side_t;

    // 400 + floor((6*duty-40)*515/90) for duty 7..21
    function automatic logic [LVL_W-1:0] evse_level(input logic [DUTY_W-1:0] duty);
        logic [LVL_W-1:0] v;
        unique case (duty)
            7'd7:    v = 10'd411;
            7'd8:    v = 10'd445;
            7'd9:    v = 10'd480;
            7'd10:   v = 10'd514;
            7'd11:   v = 10'd548;
            7'd12:   v = 10'd583;
            7'd13:   v = 10'd617;
            7'd14:   v = 10'd651;
            7'd15:   v = 10'd686;
            7'd16:   v = 10'd720;
            7'd17:   v = 10'd754;
            7'd18:   v = 10'd789;
            7'd19:   v = 10'd823;
            7'd20:   v = 10'd857;
            7'd21:   v = 10'd892;
            default: v = 10'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/charge_pwm_limiter.sv -----
// Charge PWM limiter top level: full datapath pipeline and config registers.
// Depends on chg_pkg.
`default_nettype none
// Turns one measurement item into a charger PWM compare value 0..915. One item
// may enter every clock while s_tready is high; it passes through the stages
// (1 classify, 9 ratio divider, 7 power, 1 level, 1 derate multiply,
// 1 scale by 1/200, output register). The whole pipe advances
// together whenever the output register is empty or being taken, so s_tready
// drops only while a result sits unread. Configuration writes are always
// accepted; they take effect on the next accepted item, so write them while
// the pipe is empty.
module charge_pwm_limiter #(
    parameter int unsigned CELLS = chg_pkg::DEF_CELLS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // config write channel
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [chg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [chg_pkg::CFG_DAT_W-1:0] cfg_data,
    // measurement items
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // s_tdata, from bit 0: lowest_cell_mv[12:0], highest_cell_mv[25:13],
    // pack_cv[41:26], cell_temp_dc[52:42], pilot_duty[59:53],
    // charger_enable[60], end_of_charge[61], trickle[62], zero pad[63]
    input  wire logic [63:0]  s_tdata,
    // results
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // m_tdata, from bit 0: pwm_level[9:0], zero pad[15:10]
    output logic [15:0]       m_tdata
);
    import chg_pkg::*;

    localparam int unsigned CW   = $clog2(CELLS + 1);
    localparam int unsigned LPW  = CW + MV_W;
    localparam int unsigned CMPW = (LPW > 20) ? LPW : 20;

    // ---------------- configuration registers ----------------
    logic [EXP_W-1:0]         up_exp_reg, down_exp_reg;
    logic [MV_W-1:0]          low_reg, taper_reg, limit_reg;
    logic signed [TEMP_W-1:0] tmin_reg, tpref_reg, tmax_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_exp_reg   <= RST_RAMP_UP;
            down_exp_reg <= RST_RAMP_DOWN;
            low_reg      <= RST_CELL_LOW;
            taper_reg    <= RST_TAPER;
            limit_reg    <= RST_LIMIT;
            tmin_reg     <= RST_TEMP_MIN;
            tpref_reg    <= RST_TEMP_PREF;
            tmax_reg     <= RST_TEMP_MAX;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                IDX_RAMP_UP:   up_exp_reg   <= cfg_data[EXP_W-1:0];
                IDX_RAMP_DOWN: down_exp_reg <= cfg_data[EXP_W-1:0];
                IDX_CELL_LOW:  low_reg      <= cfg_data;
                IDX_TAPER:     taper_reg    <= cfg_data;
                IDX_LIMIT:     limit_reg    <= cfg_data;
                IDX_TEMP_MIN:  tmin_reg     <= cfg_data[TEMP_W-1:0];
                IDX_TEMP_PREF: tpref_reg    <= cfg_data[TEMP_W-1:0];
                IDX_TEMP_MAX:  tmax_reg     <= cfg_data[TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipe advance ----------------
    logic m_valid_reg;
    logic adv;
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    // ---------------- stage A: classify ----------------
    logic [MV_W-1:0]          vmin, vmax;
    logic [PACK_W-1:0]        pack;
    logic signed [TEMP_W-1:0] temp;
    logic [DUTY_W-1:0]        duty;
    logic                     en, eoc, trk;

    assign vmin = s_tdata[12:0];
    assign vmax = s_tdata[25:13];
    assign pack = s_tdata[41:26];
    assign temp = s_tdata[52:42];
    assign duty = s_tdata[59:53];
    assign en   = s_tdata[60];
    assign eoc  = s_tdata[61];
    assign trk  = s_tdata[62];

    logic [CMPW-1:0]          pack10, lim_prod;
    logic                     r_up, r_full, r_taper, r_cut, r_none;
    logic                     cold, hot, derate;
    logic signed [12:0]       fac_s;
    side_t                    a_side;
    logic [MV_W-1:0]          a_num, a_den;
    logic [EXP_W-1:0]         a_exp;

    always_comb begin
        pack10   = CMPW'({pack, 3'b000}) + CMPW'({pack, 1'b0});
        lim_prod = CMPW'(LPW'(CELLS) * LPW'(limit_reg));
        r_up     = (vmin != '0) && (vmin < low_reg);
        r_full   = (vmin >= low_reg) && (vmax <= taper_reg);
        r_taper  = (vmin >= low_reg) && (vmax >= taper_reg) && (vmax <= limit_reg);
        r_cut    = (vmin > limit_reg) || (vmax > limit_reg) || (pack10 >= lim_prod);
        r_none   = (vmin == '0) || (vmax == '0) || (pack == '0);
        cold     = temp < tmin_reg;
        hot      = temp > tmax_reg;
        derate   = (temp < tpref_reg) && (temp > tmin_reg);
        fac_s    = 13'sd200 - (13'(tpref_reg) - 13'(temp));

        a_num  = vmin;
        a_den  = low_reg;
        a_exp  = up_exp_reg;
        a_side.kind = KIND_ZERO;
        priority if (r_cut || r_none) begin
            a_side.kind = KIND_ZERO;
        end else if (r_taper) begin
            a_side.kind = KIND_RAMP;
            a_num = limit_reg - vmax;
            a_den = limit_reg - taper_reg;
            a_exp = down_exp_reg;
        end else if (r_full) begin
            a_side.kind = KIND_FULL;
        end else if (r_up) begin
            a_side.kind = KIND_RAMP;
        end else begin
            a_side.kind = KIND_ZERO;
        end
        // temperature cut-off, deep derating, disable and end of charge
        if (cold || hot || !en || eoc || (derate && fac_s <= 13'sd0)) begin
            a_side.kind = KIND_ZERO;
        end
        a_side.factor   = derate ? fac_s[7:0] : FACTOR_ONE;
        a_side.trickle  = trk;
        a_side.evse     = (duty >= 7'd7) && (duty <= 7'd21);
        a_side.evse_lvl = evse_level(duty);
    end

    // ---------------- ratio divider: num*65536/den ----------------
    logic                     dv_v_reg   [DIV_STAGES+1];
    logic [MV_W-1:0]          dv_rem_reg [DIV_STAGES+1];
    logic [RATIO_W-1:0]       dv_q_reg   [DIV_STAGES+1];
    logic [MV_W-1:0]          dv_den_reg [DIV_STAGES+1];
    logic [EXP_W-1:0]         dv_exp_reg [DIV_STAGES+1];
    side_t                    dv_side_reg[DIV_STAGES+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_v_reg[0] <= s_tvalid;
        end
        if (adv) begin
            dv_rem_reg[0]  <= a_num;
            dv_q_reg[0]    <= '0;
            dv_den_reg[0]  <= a_den;
            dv_exp_reg[0]  <= a_exp;
            dv_side_reg[0] <= a_side;
        end
    end

    for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
        logic [MV_W:0]        rem_w;
        logic [RATIO_W-1:0]   q_w;
        logic [MV_W-1:0]      rem_next;
        logic [RATIO_W-1:0]   q_next;

        always_comb begin
            rem_w = {1'b0, dv_rem_reg[s-1]};
            q_w   = dv_q_reg[s-1];
            for (int k = 0; k < DIV_PER_STG; k++) begin
                if ((s - 1) * DIV_PER_STG + k < DIV_STEPS) begin
                    if ((s - 1) * DIV_PER_STG + k != 0) begin
                        rem_w = {rem_w[MV_W-1:0], 1'b0};
                    end
                    if (rem_w >= {1'b0, dv_den_reg[s-1]}) begin
                        rem_w = rem_w - {1'b0, dv_den_reg[s-1]};
                        q_w   = {q_w[RATIO_W-2:0], 1'b1};
                    end else begin
                        q_w   = {q_w[RATIO_W-2:0], 1'b0};
                    end
                end
            end
            rem_next = rem_w[MV_W-1:0];
            q_next   = q_w;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[s] <= 1'b0;
            end else if (adv) begin
                dv_v_reg[s] <= dv_v_reg[s-1];
            end
            if (adv) begin
                dv_rem_reg[s]  <= rem_next;
                dv_q_reg[s]    <= q_next;
                dv_den_reg[s]  <= dv_den_reg[s-1];
                dv_exp_reg[s]  <= dv_exp_reg[s-1];
                dv_side_reg[s] <= dv_side_reg[s-1];
            end
        end
    end

    // ---------------- power: r = (r*x)>>16, e times ----------------
    logic                     pw_v_reg   [POW_STAGES+1];
    logic [RATIO_W-1:0]       pw_x_reg   [POW_STAGES+1];
    logic [RATIO_W-1:0]       pw_r_reg   [POW_STAGES+1];
    logic [EXP_W-1:0]         pw_exp_reg [POW_STAGES+1];
    side_t                    pw_side_reg[POW_STAGES+1];

    // a zero span (taper start at the limit) reads as ratio zero
    always_comb begin
        pw_v_reg[0]    = dv_v_reg[DIV_STAGES];
        pw_x_reg[0]    = (dv_den_reg[DIV_STAGES] == '0) ? '0 : dv_q_reg[DIV_STAGES];
        pw_r_reg[0]    = RATIO_W'(17'h10000);
        pw_exp_reg[0]  = dv_exp_reg[DIV_STAGES];
        pw_side_reg[0] = dv_side_reg[DIV_STAGES];
    end

    for (genvar j = 1; j <= POW_STAGES; j++) begin : g_pow
        logic [2*RATIO_W-1:0] prod;
        logic [RATIO_W-1:0]   r_next;

        always_comb begin
            prod   = pw_r_reg[j-1] * pw_x_reg[j-1];
            r_next = (EXP_W'(j - 1) < pw_exp_reg[j-1]) ? prod[RATIO_W+15:16]
                                                       : pw_r_reg[j-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pw_v_reg[j] <= 1'b0;
            end else if (adv) begin
                pw_v_reg[j] <= pw_v_reg[j-1];
            end
            if (adv) begin
                pw_x_reg[j]    <= pw_x_reg[j-1];
                pw_r_reg[j]    <= r_next;
                pw_exp_reg[j]  <= pw_exp_reg[j-1];
                pw_side_reg[j] <= pw_side_reg[j-1];
            end
        end
    end

    // ---------------- level: 130 + 785*r, Q16 ----------------
    logic                     lv_v_reg;
    logic [LVLQ_W-1:0]        lv_lvl_reg, lv_lvl_next;
    side_t                    lv_side_reg;

    always_comb begin
        unique case (pw_side_reg[POW_STAGES].kind)
            KIND_FULL: lv_lvl_next = {LVL_MAX, 16'h0000};
            KIND_RAMP: lv_lvl_next = {LVL_RUN, 16'h0000}
                                   + LVLQ_W'(pw_r_reg[POW_STAGES]) * LVLQ_W'(10'd785);
            default:   lv_lvl_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lv_v_reg <= 1'b0;
        end else if (adv) begin
            lv_v_reg <= pw_v_reg[POW_STAGES];
        end
        if (adv) begin
            lv_lvl_reg  <= lv_lvl_next;
            lv_side_reg <= pw_side_reg[POW_STAGES];
        end
    end

    // ---------------- derating multiply: level * factor ----------------
    logic                     mu_v_reg;
    logic [PROD_W-1:0]        mu_p_reg;
    side_t                    mu_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu_v_reg <= 1'b0;
        end else if (adv) begin
            mu_v_reg <= lv_v_reg;
        end
        if (adv) begin
            mu_p_reg    <= PROD_W'(lv_lvl_reg) * PROD_W'(lv_side_reg.factor);
            mu_side_reg <= lv_side_reg;
        end
    end

    // ---------------- scale: /200 and drop the fraction ----------------
    // p/(200*2^16) = (p>>19)/25; p>>19 stays below 2^15, where
    // (n*ceil(2^20/25))>>20 is exactly n/25
    logic                     sc_v_reg;
    logic [SC_W-1:0]          sc_q_reg;
    logic                     sc_big_reg;
    side_t                    sc_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sc_v_reg <= 1'b0;
        end else if (adv) begin
            sc_v_reg <= mu_v_reg;
        end
        if (adv) begin
            sc_q_reg    <= SC_W'(mu_p_reg[PROD_W-1:SCALE_SH]) * SC_W'(RECIP25);
            sc_big_reg  <= mu_p_reg >= ABOVE_ONE;
            sc_side_reg <= mu_side_reg;
        end
    end

    // ---------------- speed rules, truncate, clamp ----------------
    logic [LVL_W-1:0]         out_next;
    logic [LVL_W-1:0]         m_lvl_reg;

    always_comb begin
        out_next = sc_q_reg[RECIP_SH+LVL_W-1:RECIP_SH];
        if (sc_big_reg) begin
            if (sc_side_reg.trickle) begin
                out_next = LVL_RUN;
            end
            if (sc_side_reg.evse) begin
                out_next = sc_side_reg.evse_lvl;
            end
        end
        if (out_next > LVL_MAX) begin
            out_next = LVL_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= sc_v_reg;
        end
        if (adv) begin
            m_lvl_reg <= out_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b000000, m_lvl_reg};

endmodule
`default_nettype wire
